// ----- design/ufmr_pkg.sv -----
// Shared types and constants for the union-find engine.
// Depends on nothing; the csr, engine, top-level and checker files import it.
package ufmr_pkg;

   // Fixed field widths of the request and response beats
   localparam int ELEM_W  = 10;
   localparam int ROOT_W  = 10;
   localparam int COUNT_W = 11;

   // Register file
   localparam int                 CSR_ADDR_W          = 3;
   localparam int                 CSR_DATA_W          = 32;
   localparam logic               REG_ELEMENTS_IN_USE = 1'b0;
   localparam logic [COUNT_W-1:0] COUNT_RESET         = 11'd1024;

   // Request actions
   localparam logic ACT_FIND = 1'b0;
   localparam logic ACT_JOIN = 1'b1;

   // One finished response
   typedef struct packed {
      logic [ROOT_W-1:0] root;
      logic              already_same_set;
      logic              index_error;
   } result_type;

endpackage

// ----- design/ufmr_parent_mem.sv -----
// Parent table storage: one write port, one registered read port.
// Same-cycle write and read of one entry returns the new data.
module ufmr_parent_mem #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(MAX_ELEMENTS)-1:0] wr_addr,
   input  logic [$clog2(MAX_ELEMENTS)-1:0] wr_data,
   input  logic [$clog2(MAX_ELEMENTS)-1:0] rd_addr,
   output logic [$clog2(MAX_ELEMENTS)-1:0] rd_data
);
   localparam int IDX_W = $clog2(MAX_ELEMENTS);

   logic [IDX_W-1:0] parent_ff [MAX_ELEMENTS];
   logic [IDX_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         parent_ff[wr_addr] <= wr_data;
      end
   end

   // read port, write-first on a collision
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= parent_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/ufmr_csr.sv -----
// APB-style register block holding the element count.
// Depends on ufmr_pkg.
module ufmr_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [ufmr_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [ufmr_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [ufmr_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready,
   output logic [ufmr_pkg::COUNT_W-1:0]       elements_in_use
);
   import ufmr_pkg::*;

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               reg_sel;

   // word index is the bit above the byte offset
   assign reg_sel = (paddr[2] == REG_ELEMENTS_IN_USE);

   always_comb begin
      count_in = count_ff;
      if (psel && penable && pwrite && reg_sel) begin
         count_in = pwdata[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else begin
         count_ff <= count_in;
      end
   end

   assign prdata          = reg_sel ? CSR_DATA_W'(count_ff) : '0;
   assign pready          = 1'b1;
   assign elements_in_use = count_ff;

endmodule

// ----- design/ufmr_engine.sv -----
// Sequencer for find and join: walks the parent chain, compresses it and links roots.
// Depends on ufmr_pkg; drives the ufmr_parent_mem ports.
module ufmr_engine #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_action,
   input  logic [ufmr_pkg::ELEM_W-1:0]     req_element_a,
   input  logic [ufmr_pkg::ELEM_W-1:0]     req_element_b,
   input  logic [ufmr_pkg::COUNT_W-1:0]    elements_in_use,
   output logic                            res_valid,
   input  logic                            res_take,
   output ufmr_pkg::result_type            res,
   output logic                            mem_wr_en,
   output logic [$clog2(MAX_ELEMENTS)-1:0] mem_wr_addr,
   output logic [$clog2(MAX_ELEMENTS)-1:0] mem_wr_data,
   output logic [$clog2(MAX_ELEMENTS)-1:0] mem_rd_addr,
   input  logic [$clog2(MAX_ELEMENTS)-1:0] mem_rd_data
);
   import ufmr_pkg::*;

   localparam int               IDX_W    = $clog2(MAX_ELEMENTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ELEMENTS - 1);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_WALK  = 5'b00100,
      ST_COMP  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic             act_ff, act_in;
   logic             phase_ff, phase_in;
   logic [IDX_W-1:0] b_ff, b_in;
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic [IDX_W-1:0] start_ff, start_in;
   logic [IDX_W-1:0] root_ff, root_in;
   logic [IDX_W-1:0] ra_ff, ra_in;
   result_type       res_ff, res_in;

   logic [IDX_W-1:0] a_idx;
   logic [IDX_W-1:0] b_idx;
   logic             bad_a;
   logic             bad_b;
   logic             bad_req;

   // range check against the configured count and the table size
   assign a_idx   = IDX_W'(req_element_a);
   assign b_idx   = IDX_W'(req_element_b);
   assign bad_a   = ({1'b0, req_element_a} >= elements_in_use) ||
                    (32'(req_element_a) >= 32'(MAX_ELEMENTS));
   assign bad_b   = ({1'b0, req_element_b} >= elements_in_use) ||
                    (32'(req_element_b) >= 32'(MAX_ELEMENTS));
   assign bad_req = bad_a || ((req_action == ACT_JOIN) && bad_b);

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      act_in      = act_ff;
      phase_in    = phase_ff;
      b_in        = b_ff;
      cur_in      = cur_ff;
      start_in    = start_ff;
      root_in     = root_ff;
      ra_in       = ra_ff;
      res_in      = res_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = '0;
      mem_rd_addr = '0;

      case (state_ff)
         // reset sweep: entry i points at itself
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = clr_ff;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end

         // take a beat, start reading element_a
         ST_IDLE: begin
            mem_rd_addr = a_idx;
            if (req_valid) begin
               act_in   = req_action;
               b_in     = b_idx;
               cur_in   = a_idx;
               start_in = a_idx;
               phase_in = 1'b0;
               if (bad_req) begin
                  res_in   = '{root: '0, already_same_set: 1'b0, index_error: 1'b1};
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end

         // one chain hop per cycle until an entry points at itself
         ST_WALK: begin
            if (mem_rd_data == cur_ff) begin
               root_in     = cur_ff;
               cur_in      = start_ff;
               mem_rd_addr = start_ff;
               state_in    = ST_COMP;
            end else begin
               cur_in      = mem_rd_data;
               mem_rd_addr = mem_rd_data;
            end
         end

         // second pass: point every visited entry at the root
         ST_COMP: begin
            if (cur_ff != root_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = cur_ff;
               mem_wr_data = root_ff;
               cur_in      = mem_rd_data;
               mem_rd_addr = mem_rd_data;
            end else if (act_ff == ACT_FIND) begin
               res_in   = '{root: ROOT_W'(root_ff), already_same_set: 1'b0,
                            index_error: 1'b0};
               state_in = ST_DONE;
            end else if (!phase_ff) begin
               // first root of a join done, go find element_b
               ra_in       = root_ff;
               phase_in    = 1'b1;
               cur_in      = b_ff;
               start_in    = b_ff;
               mem_rd_addr = b_ff;
               state_in    = ST_WALK;
            end else begin
               // link the larger root under the smaller
               if (ra_ff == root_ff) begin
                  res_in = '{root: ROOT_W'(ra_ff), already_same_set: 1'b1,
                             index_error: 1'b0};
               end else if (ra_ff < root_ff) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = root_ff;
                  mem_wr_data = ra_ff;
                  res_in      = '{root: ROOT_W'(ra_ff), already_same_set: 1'b0,
                                  index_error: 1'b0};
               end else begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = ra_ff;
                  mem_wr_data = root_ff;
                  res_in      = '{root: ROOT_W'(root_ff), already_same_set: 1'b0,
                                  index_error: 1'b0};
               end
               state_in = ST_DONE;
            end
         end

         // wait for the output register to free up
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      act_ff   <= act_in;
      phase_ff <= phase_in;
      b_ff     <= b_in;
      cur_ff   <= cur_in;
      start_ff <= start_in;
      root_ff  <= root_in;
      ra_ff    <= ra_in;
      res_ff   <= res_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res       = res_ff;

endmodule

// ----- design/union_find_min_root.sv -----
// Top level of the union-find engine: register block, sequencer, parent table, output register.
// Depends on ufmr_pkg, ufmr_csr, ufmr_engine and ufmr_parent_mem.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | req_action, req_element_a, req_element_b
//   rsp     | out       | rsp_valid / rsp_stall | rsp_root, rsp_already_same_set, rsp_index_error
//   csr     | in/out    | psel/penable/pready   | paddr, pwdata, prdata (elements_in_use)
//
// A find reads the table once per hop on the walk, then reads and writes once per hop on
// the compression pass. A join runs both walks and compressions back to back; the link
// write is made in the final step of the second compression pass. Out-of-range requests
// skip the walk and go straight to the done state.
// After reset a sweep writes all MAX_ELEMENTS table entries; req_stall stays high.
// A stalled response in the output register holds the engine in its done state, so req_stall stays high.
module union_find_min_root #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_action,
   input  logic [ufmr_pkg::ELEM_W-1:0]      req_element_a,
   input  logic [ufmr_pkg::ELEM_W-1:0]      req_element_b,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [ufmr_pkg::ROOT_W-1:0]      rsp_root,
   output logic                             rsp_already_same_set,
   output logic                             rsp_index_error,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [ufmr_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [ufmr_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [ufmr_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);
   import ufmr_pkg::*;

   localparam int IDX_W = $clog2(MAX_ELEMENTS);

   logic [COUNT_W-1:0] elements_in_use;
   logic               res_valid;
   logic               res_take;
   result_type         res;
   logic               mem_wr_en;
   logic [IDX_W-1:0]   mem_wr_addr;
   logic [IDX_W-1:0]   mem_wr_data;
   logic [IDX_W-1:0]   mem_rd_addr;
   logic [IDX_W-1:0]   mem_rd_data;

   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;

   ufmr_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .elements_in_use (elements_in_use)
   );

   ufmr_engine #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_element_a   (req_element_a),
      .req_element_b   (req_element_b),
      .elements_in_use (elements_in_use),
      .res_valid       (res_valid),
      .res_take        (res_take),
      .res             (res),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_addr     (mem_rd_addr),
      .mem_rd_data     (mem_rd_data)
   );

   ufmr_parent_mem #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_parent_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // output register: load when empty or being drained this cycle
   assign res_take = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_root             = rsp_ff.root;
   assign rsp_already_same_set = rsp_ff.already_same_set;
   assign rsp_index_error      = rsp_ff.index_error;

endmodule

// ----- design/ufmr_checker.sv -----
// Port-level checks for the union-find engine, bound to the top level.
// Depends on ufmr_pkg and union_find_min_root.
module ufmr_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [ufmr_pkg::ROOT_W-1:0] rsp_root,
   input logic                        rsp_already_same_set,
   input logic                        rsp_index_error
);
   import ufmr_pkg::*;

   // a stalled response beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_root) &&
         $stable(rsp_already_same_set) && $stable(rsp_index_error))
      else $error("stalled response beat changed");

   // an index error carries no root and no same-set flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_index_error |-> (rsp_root == '0) && !rsp_already_same_set)
      else $error("index error response with payload");

   // the table sweep holds off requests right after reset
   assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> req_stall)
      else $error("request taken during table sweep");

   // one request at a time: the engine is busy after taking a beat
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken back to back");

endmodule

bind union_find_min_root ufmr_checker u_ufmr_checker (.*);
